>>> design/rsc_pkg.sv
// Shared constants and types of the root-sum constraint unit.
`timescale 1ns / 1ps
package rsc_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int IDX_W            = 10;
  localparam int CFG_IDX_W        = 1;
  localparam int DIV_NUM_W        = 96;
  localparam int DIV_DEN_W        = 75;

  localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd1;

  typedef struct packed {
    logic busy;
    logic done;
    logic fault;
  } div_stat_t;

endpackage

>>> design/rsc_if.sv
// Handshake channels of the root-sum constraint unit: items, results, configuration.
`timescale 1ns / 1ps
interface rsc_item_if;
  logic               valid;
  logic               ready;
  logic        [31:0] root_source;
  logic signed [31:0] step_weight;
  logic               final_element;
  modport source (output valid, root_source, step_weight, final_element, input ready);
  modport sink   (input valid, root_source, step_weight, final_element, output ready);
endinterface

interface rsc_result_if;
  logic               valid;
  logic               ready;
  logic        [9:0]  grad_index;
  logic signed [63:0] grad_value;
  logic signed [63:0] total_value;
  logic               total_valid;
  logic               run_end;
  logic               math_fault;
  modport source (output valid, grad_index, grad_value, total_value, total_valid, run_end,
                  math_fault, input ready);
  modport sink   (input valid, grad_index, grad_value, total_value, total_valid, run_end,
                  math_fault, output ready);
endinterface

interface rsc_cfg_if;
  logic               valid;
  logic               ready;
  logic               index;
  logic signed [31:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

>>> design/rsc_div.sv
// Bit-serial restoring divider with signed saturating result.
`timescale 1ns / 1ps
module rsc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rsc_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [rsc_pkg::DIV_DEN_W-1:0]     den_i,
  input  logic                              neg_i,
  output logic signed [63:0]                quo_o,
  output rsc_pkg::div_stat_t                stat_o
);
  import rsc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 fault_q, fault_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic                 neg_q, neg_d;
  logic signed [63:0]   quo_q, quo_d;

  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;
  logic [DIV_NUM_W-1:0] q_next;
  logic                 ovf;
  logic [63:0]          mag;

  assign rem_sh = {rem_q, num_q[DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign q_next = {num_q[DIV_NUM_W-2:0], ge};
  assign ovf    = (|q_next[DIV_NUM_W-1:64]) ||
                  (neg_q ? (q_next[63] && (|q_next[62:0])) : q_next[63]);
  assign mag    = ovf ? (neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : q_next[63:0];

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    fault_d = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    quo_d   = quo_q;
    if (start_i) begin
      if (den_i == '0) begin
        done_d  = 1'b1;
        fault_d = 1'b1;
        quo_d   = '0;
      end else begin
        busy_d = 1'b1;
        cnt_d  = '0;
        num_d  = num_i;
        rem_d  = '0;
        den_d  = den_i;
        neg_d  = neg_i;
      end
    end else if (busy_q) begin
      num_d = q_next;
      rem_d = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
      cnt_d = CNT_W'(cnt_q + 1'b1);
      if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        fault_d = ovf;
        quo_d   = neg_q ? -$signed(mag) : $signed(mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      fault_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      fault_q <= fault_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
  end

  assign quo_o        = quo_q;
  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign stat_o.fault = fault_q;

endmodule

>>> design/root_sum_constraint_with_gradient_unit.sv
// Top level of the root-sum constraint unit with streamed gradient output.
`timescale 1ns / 1ps
// The unit takes one vector element per transaction (Q16.16 value and weight),
// forms its square root bit-serially, and accumulates weight / (root sum) into
// the constraint value while building the gradient entries. Each element after
// the first emits the previous gradient entry; the last element (or the element
// at index MAX_ELEMENTS-1) also emits its own entry with the finished total,
// after which the vector state clears. All heavy math is serial: a two-bit-per-
// cycle square root, a shift-add multiplier and one shared 96-step restoring
// divider. A first element runs the root, the reciprocal term, the root sum
// squared and its own gradient term; a middle element adds the neighbor gradient
// term and one output state; a final element adds the gain division, the gain
// product and the total and last-output states. One item is in work at a time and
// a new one is taken only once the previous item has handed off its results;
// a result waits in the output register without holding up the sequencer
// unless a second result must be loaded. Configuration writes are always taken.
module root_sum_constraint_with_gradient_unit #(
  parameter int MAX_ELEMENTS = rsc_pkg::MAX_ELEMENTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsc_item_if.sink    item_i,
  rsc_result_if.source result_o,
  rsc_cfg_if.sink     cfg_i
);
  import rsc_pkg::*;

  localparam int CNT_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQRT = 4'd1;
  localparam logic [3:0] ST_DA   = 4'd2;
  localparam logic [3:0] ST_M1   = 4'd3;
  localparam logic [3:0] ST_MB   = 4'd4;
  localparam logic [3:0] ST_DB   = 4'd5;
  localparam logic [3:0] ST_O1   = 4'd6;
  localparam logic [3:0] ST_MC   = 4'd7;
  localparam logic [3:0] ST_DC   = 4'd8;
  localparam logic [3:0] ST_DD   = 4'd9;
  localparam logic [3:0] ST_MA   = 4'd10;
  localparam logic [3:0] ST_TOT  = 4'd11;
  localparam logic [3:0] ST_O2   = 4'd12;

  // Saturating 64-bit add/sub; bit 64 of the result flags saturation.
  function automatic logic [64:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return {1'b1, s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}};
    return {1'b0, s[63:0]};
  endfunction

  function automatic logic [64:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return {1'b1, s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}};
    return {1'b0, s[63:0]};
  endfunction

  // Configuration
  logic signed [31:0] alpha_q, alpha_d;
  logic signed [31:0] boff_q, boff_d;

  // Vector state
  logic [3:0]         state_q, state_d;
  logic [23:0]        prev_q, prev_d;
  logic signed [63:0] pend_q, pend_d;
  logic signed [63:0] sum_q, sum_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               fault_q, fault_d;

  // Per-item working registers
  logic signed [31:0] delta_q, delta_d;
  logic               fin_q, fin_d;
  logic [23:0]        y_q, y_d;
  logic [24:0]        dsum_q, dsum_d;
  logic [49:0]        dd_q, dd_d;
  logic signed [63:0] tmp_q, tmp_d;
  logic [4:0]         step_q, step_d;

  // Square root shift registers
  logic [47:0]        sq_v_q, sq_v_d;
  logic [25:0]        sq_rem_q, sq_rem_d;
  logic [23:0]        sq_root_q, sq_root_d;

  // Shift-add multiplier
  logic [74:0]        mul_acc_q, mul_acc_d;
  logic [49:0]        mul_mc_q, mul_mc_d;
  logic [24:0]        mul_mp_q, mul_mp_d;

  // Divider launch
  logic                 dstart_q, dstart_d;
  logic [DIV_NUM_W-1:0] dnum_q, dnum_d;
  logic [DIV_DEN_W-1:0] dden_q, dden_d;
  logic                 dneg_q, dneg_d;
  logic signed [63:0]   div_quo;
  div_stat_t            div_stat;

  // Output register
  logic               ov_q, ov_d;
  logic [9:0]         o_idx_q, o_idx_d;
  logic signed [63:0] o_grad_q, o_grad_d;
  logic signed [63:0] o_tot_q, o_tot_d;
  logic               o_fin_q, o_fin_d;
  logic               o_fault_q, o_fault_d;

  logic        slot_free;
  logic        item_acc;
  logic [27:0] sq_rem_sh;
  logic [27:0] sq_trial;
  logic        sq_ge;
  logic [23:0] sq_root_nx;
  logic [74:0] mul_nx;
  logic [31:0] dmag;
  logic [31:0] amag;
  logic [64:0] r_sat;
  logic [64:0] r_sat2;
  logic [63:0] prod_s;

  rsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart_q),
    .num_i  (dnum_q),
    .den_i  (dden_q),
    .neg_i  (dneg_q),
    .quo_o  (div_quo),
    .stat_o (div_stat)
  );

  assign slot_free    = !ov_q || result_o.ready;
  assign item_i.ready = (state_q == ST_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;

  assign sq_rem_sh  = {sq_rem_q, sq_v_q[47:46]};
  assign sq_trial   = {2'b00, sq_root_q, 2'b01};
  assign sq_ge      = sq_rem_sh >= sq_trial;
  assign sq_root_nx = {sq_root_q[22:0], sq_ge};

  assign mul_nx = {mul_acc_q[73:0], 1'b0} + (mul_mp_q[24] ? {25'd0, mul_mc_q} : 75'd0);

  assign dmag   = delta_q[31] ? 32'(-delta_q) : 32'(delta_q);
  assign amag   = alpha_q[31] ? 32'(-alpha_q) : 32'(alpha_q);
  assign prod_s = alpha_q[31] ? -64'(mul_nx) : 64'(mul_nx);

  always_comb begin
    alpha_d   = alpha_q;
    boff_d    = boff_q;
    state_d   = state_q;
    prev_d    = prev_q;
    pend_d    = pend_q;
    sum_d     = sum_q;
    count_d   = count_q;
    fault_d   = fault_q;
    delta_d   = delta_q;
    fin_d     = fin_q;
    y_d       = y_q;
    dsum_d    = dsum_q;
    dd_d      = dd_q;
    tmp_d     = tmp_q;
    step_d    = step_q;
    sq_v_d    = sq_v_q;
    sq_rem_d  = sq_rem_q;
    sq_root_d = sq_root_q;
    mul_acc_d = mul_acc_q;
    mul_mc_d  = mul_mc_q;
    mul_mp_d  = mul_mp_q;
    dstart_d  = 1'b0;
    dnum_d    = dnum_q;
    dden_d    = dden_q;
    dneg_d    = dneg_q;
    ov_d      = ov_q && !result_o.ready;
    o_idx_d   = o_idx_q;
    o_grad_d  = o_grad_q;
    o_tot_d   = o_tot_q;
    o_fin_d   = o_fin_q;
    o_fault_d = o_fault_q;
    r_sat     = '0;
    r_sat2    = '0;

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SLOPE:  alpha_d = cfg_i.wdata;
        REG_OFFSET: boff_d  = cfg_i.wdata;
        default:    ;
      endcase
    end

    // Shift-add step runs in every multiply state.
    if (state_q == ST_M1 || state_q == ST_MB || state_q == ST_MC || state_q == ST_MA) begin
      mul_acc_d = mul_nx;
      mul_mp_d  = {mul_mp_q[23:0], 1'b0};
      step_d    = 5'(step_q + 1'b1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          sq_v_d    = {item_i.root_source, 16'd0};
          sq_rem_d  = '0;
          sq_root_d = '0;
          step_d    = '0;
          delta_d   = item_i.step_weight;
          fin_d     = item_i.final_element || (count_q == CNT_W'(MAX_ELEMENTS - 1));
          state_d   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sq_root_d = sq_root_nx;
        sq_rem_d  = sq_ge ? 26'(sq_rem_sh - sq_trial) : sq_rem_sh[25:0];
        sq_v_d    = {sq_v_q[45:0], 2'b00};
        step_d    = 5'(step_q + 1'b1);
        if (step_q == 5'd23) begin
          // Launch the reciprocal term delta / (y + y_prev).
          y_d      = sq_root_nx;
          dsum_d   = {1'b0, sq_root_nx} + {1'b0, prev_q};
          dstart_d = 1'b1;
          dnum_d   = {32'd0, dmag, 32'd0};
          dden_d   = DIV_DEN_W'({1'b0, sq_root_nx} + {1'b0, prev_q});
          dneg_d   = delta_q[31];
          state_d  = ST_DA;
        end
      end
      ST_DA: begin
        if (div_stat.done) begin
          r_sat     = sat_add(sum_q, div_quo);
          sum_d     = r_sat[63:0];
          fault_d   = fault_q | div_stat.fault | r_sat[64];
          mul_acc_d = '0;
          mul_mc_d  = 50'(dsum_q);
          mul_mp_d  = dsum_q;
          step_d    = '0;
          state_d   = ST_M1;
        end
      end
      ST_M1: begin
        if (step_q == 5'd24) begin
          dd_d      = mul_nx[49:0];
          mul_acc_d = '0;
          mul_mc_d  = mul_nx[49:0];
          step_d    = '0;
          if (count_q != '0) begin
            mul_mp_d = {1'b0, prev_q};
            state_d  = ST_MB;
          end else begin
            mul_mp_d = {1'b0, y_q};
            state_d  = ST_MC;
          end
        end
      end
      ST_MB: begin
        if (step_q == 5'd24) begin
          dstart_d = 1'b1;
          dnum_d   = {1'b0, dmag, 63'd0};
          dden_d   = mul_nx;
          dneg_d   = delta_q[31];
          state_d  = ST_DB;
        end
      end
      ST_DB: begin
        if (div_stat.done) begin
          r_sat   = sat_sub(pend_q, div_quo);
          tmp_d   = r_sat[63:0];
          fault_d = fault_q | div_stat.fault | r_sat[64];
          state_d = ST_O1;
        end
      end
      ST_O1: begin
        if (slot_free) begin
          ov_d      = 1'b1;
          o_idx_d   = 10'(CNT_W'(count_q - 1'b1));
          o_grad_d  = tmp_q;
          o_tot_d   = '0;
          o_fin_d   = 1'b0;
          o_fault_d = fault_q;
          mul_acc_d = '0;
          mul_mc_d  = dd_q;
          mul_mp_d  = {1'b0, y_q};
          step_d    = '0;
          state_d   = ST_MC;
        end
      end
      ST_MC: begin
        if (step_q == 5'd24) begin
          dstart_d = 1'b1;
          dnum_d   = {1'b0, dmag, 63'd0};
          dden_d   = mul_nx;
          dneg_d   = delta_q[31];
          state_d  = ST_DC;
        end
      end
      ST_DC: begin
        if (div_stat.done) begin
          r_sat   = sat_sub(64'sd0, div_quo);
          pend_d  = r_sat[63:0];
          fault_d = fault_q | div_stat.fault | r_sat[64];
          if (fin_q) begin
            dstart_d = 1'b1;
            dnum_d   = DIV_NUM_W'({amag, 31'd0});
            dden_d   = DIV_DEN_W'(y_q);
            dneg_d   = alpha_q[31];
            state_d  = ST_DD;
          end else begin
            prev_d  = y_q;
            count_d = CNT_W'(count_q + 1'b1);
            state_d = ST_IDLE;
          end
        end
      end
      ST_DD: begin
        if (div_stat.done) begin
          r_sat     = sat_sub(pend_q, div_quo);
          pend_d    = r_sat[63:0];
          fault_d   = fault_q | div_stat.fault | r_sat[64];
          mul_acc_d = '0;
          mul_mc_d  = 50'(amag);
          mul_mp_d  = {1'b0, y_q};
          step_d    = '0;
          state_d   = ST_MA;
        end
      end
      ST_MA: begin
        if (step_q == 5'd24) begin
          r_sat   = sat_sub(sum_q, prod_s);
          tmp_d   = r_sat[63:0];
          fault_d = fault_q | r_sat[64];
          state_d = ST_TOT;
        end
      end
      ST_TOT: begin
        r_sat2  = sat_sub(tmp_q, {{16{boff_q[31]}}, boff_q, 16'd0});
        tmp_d   = r_sat2[63:0];
        fault_d = fault_q | r_sat2[64];
        state_d = ST_O2;
      end
      ST_O2: begin
        if (slot_free) begin
          ov_d      = 1'b1;
          o_idx_d   = 10'(count_q);
          o_grad_d  = pend_q;
          o_tot_d   = tmp_q;
          o_fin_d   = 1'b1;
          o_fault_d = fault_q;
          // Drop all vector state for the next run.
          prev_d    = '0;
          pend_d    = '0;
          sum_d     = '0;
          count_d   = '0;
          fault_d   = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= '0;
      boff_q   <= '0;
      state_q  <= ST_IDLE;
      prev_q   <= '0;
      pend_q   <= '0;
      sum_q    <= '0;
      count_q  <= '0;
      fault_q  <= 1'b0;
      step_q   <= '0;
      dstart_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      alpha_q  <= alpha_d;
      boff_q   <= boff_d;
      state_q  <= state_d;
      prev_q   <= prev_d;
      pend_q   <= pend_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
      fault_q  <= fault_d;
      step_q   <= step_d;
      dstart_q <= dstart_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q   <= delta_d;
    fin_q     <= fin_d;
    y_q       <= y_d;
    dsum_q    <= dsum_d;
    dd_q      <= dd_d;
    tmp_q     <= tmp_d;
    sq_v_q    <= sq_v_d;
    sq_rem_q  <= sq_rem_d;
    sq_root_q <= sq_root_d;
    mul_acc_q <= mul_acc_d;
    mul_mc_q  <= mul_mc_d;
    mul_mp_q  <= mul_mp_d;
    dnum_q    <= dnum_d;
    dden_q    <= dden_d;
    dneg_q    <= dneg_d;
    o_idx_q   <= o_idx_d;
    o_grad_q  <= o_grad_d;
    o_tot_q   <= o_tot_d;
    o_fin_q   <= o_fin_d;
    o_fault_q <= o_fault_d;
  end

  assign result_o.valid       = ov_q;
  assign result_o.grad_index  = o_idx_q;
  assign result_o.grad_value  = o_grad_q;
  assign result_o.total_value = o_tot_q;
  assign result_o.total_valid = o_fin_q;
  assign result_o.run_end     = o_fin_q;
  assign result_o.math_fault  = o_fault_q;

  // Never launch the divider while it is still iterating.
  a_div_launch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstart_q |-> !div_stat.busy)
    else $error("divider launched while busy");

  // A divider result arrives only in a state that waits for one.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DA || state_q == ST_DB ||
                       state_q == ST_DC || state_q == ST_DD))
    else $error("divider result with no consumer");

  // A held result is never overwritten before the sink takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !result_o.ready) |=> (ov_q && $stable(o_grad_q) && $stable(o_idx_q)))
    else $error("pending result overwritten");

  // Closing a vector leaves the element count, fault flag and running sum cleared.
  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_O2 && slot_free) |=> (count_q == '0 && !fault_q && sum_q == '0))
    else $error("vector state not cleared at run end");

endmodule

>>> tb/sv/root_sum_constraint_with_gradient_unit_tb.sv
// Self-checking testbench of the root-sum constraint unit with streamed gradient.
`timescale 1ns / 1ps
module root_sum_constraint_with_gradient_unit_tb;
  import rsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // idle cycles
  localparam int SETTLE_CYCLES  = 700;    // covers a final item's full latency
  localparam int LONG_RUN       = 1024;   // reaches MAX_ELEMENTS to force the wrap

  typedef struct {
    logic [9:0]  idx;
    longint      grad;
    longint      total;
    logic        tv;
    logic        re;
    logic        mf;
  } grad_entry_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] w;
    logic        fin;
    logic        has_lit;  // expected entry is typed in below
    grad_entry_t lit;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  rsc_item_if   item_bus ();
  rsc_result_if res_bus ();
  rsc_cfg_if    cfg_bus ();

  root_sum_constraint_with_gradient_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (res_bus),
    .cfg_i    (cfg_bus)
  );

  // Shadow of the block: registers and per-vector state.
  longint      gain_q;
  longint      offset_q;
  logic [63:0] last_root;
  longint      held_grad;
  longint      run_sum;
  int          elem_idx;
  bit          run_fault;

  grad_entry_t expected_q[$];
  int          error_count;
  int          idle_cycles;
  int          burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor arithmetic
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] root_of(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  // Truncating quotient with sign applied afterwards; zero divisor and
  // overflow both mark the vector as faulted.
  function automatic longint quot_sat(bit neg, logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    logic [127:0] lim;
    if (den == 0) begin
      run_fault = 1'b1;
      return 0;
    end
    q   = num / den;
    lim = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
    if (q > lim) begin
      run_fault = 1'b1;
      q = lim;
    end
    return neg ? longint'(64'd0 - q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint sat_fold(longint a, longint b, bit sub);
    logic signed [64:0] s;
    s = sub ? ($signed({a[63], a}) - $signed({b[63], b}))
            : ($signed({a[63], a}) + $signed({b[63], b}));
    if (s[64] != s[63]) begin
      run_fault = 1'b1;
      return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return longint'(s[63:0]);
  endfunction

  // weight / (2 r d^2) in Q32.32
  function automatic longint grad_part(longint w, logic [63:0] r, logic [63:0] d);
    logic [127:0] num;
    logic [127:0] den;
    logic [63:0]  dsq;
    dsq = d * d;
    num = {64'd0, mag64(w)} << 63;
    den = {64'd0, r} * {64'd0, dsq};
    return quot_sat(w < 0, num, den);
  endfunction

  task automatic predict_element(logic [31:0] x, logic [31:0] w_raw, logic fin_raw);
    longint      w;
    logic [63:0] y;
    logic [63:0] d;
    longint      g;
    longint      total;
    bit          fin;
    grad_entry_t e;
    w   = longint'($signed(w_raw));
    fin = fin_raw || (elem_idx >= MAX_ELEMENTS_DEF - 1);
    y   = root_of({32'd0, x} << 16);
    d   = y + last_root;
    run_sum = sat_fold(run_sum, quot_sat(w < 0, {64'd0, mag64(w) << 32}, {64'd0, d}), 1'b0);
    if (elem_idx > 0) begin
      g = sat_fold(held_grad, grad_part(w, last_root, d), 1'b1);
      e = '{idx: 10'(elem_idx - 1), grad: g, total: 0, tv: 0, re: 0, mf: run_fault};
      expected_q.push_back(e);
    end
    held_grad = sat_fold(0, grad_part(w, y, d), 1'b1);
    if (fin) begin
      held_grad = sat_fold(held_grad,
                           quot_sat(gain_q < 0, {64'd0, mag64(gain_q) << 31}, {64'd0, y}),
                           1'b1);
      total = sat_fold(run_sum, gain_q * longint'(y), 1'b1);
      total = sat_fold(total, offset_q * 65536, 1'b1);
      e = '{idx: 10'(elem_idx), grad: held_grad, total: total, tv: 1, re: 1, mf: run_fault};
      expected_q.push_back(e);
      last_root = 0;
      held_grad = 0;
      run_sum   = 0;
      elem_idx  = 0;
      run_fault = 1'b0;
    end else begin
      last_root = y;
      elem_idx++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps.
  task automatic send_element(logic [31:0] x, logic [31:0] w, logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk_i);
        item_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    item_bus.valid         = 1'b1;
    item_bus.root_source   = x;
    item_bus.step_weight   = w;
    item_bus.final_element = fin;
    do @(posedge clk_i); while (!item_bus.ready);
    predict_element(x, w, fin);
  endtask

  // Hold the sender until every pending entry is back, then let a
  // result-free item finish before touching the registers.
  task automatic drain();
    @(negedge clk_i);
    item_bus.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.wdata = val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == REG_SLOPE) gain_q = longint'($signed(val));
    else offset_q = longint'($signed(val));
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_regs(logic [31:0] gain, logic [31:0] offs);
    drain();
    write_reg(REG_SLOPE, gain);
    write_reg(REG_OFFSET, offs);
  endtask

  function automatic logic [31:0] pick_root();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2:    return 32'($urandom_range(1, 255));
      3:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($signed($urandom_range(0, 512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  // Well-formed vectors of random length; now and then a long one.
  task automatic send_vectors(int count);
    int len;
    repeat (count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++)
        send_element(pick_root(), pick_weight(), k == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on its own pattern, with calm stretches in between
  // ---------------------------------------------------------------------------
  int stall_left;
  int calm_left;
  always @(negedge clk_i) begin
    if (calm_left > 0) begin
      calm_left--;
      res_bus.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_bus.ready = 1'b0;
    end else begin
      res_bus.ready = 1'b1;
      case ($urandom_range(0, 63))
        0:       calm_left  = $urandom_range(500, 3000);
        1, 2, 3: stall_left = $urandom_range(1, 30);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    grad_entry_t e;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result idx=%0d grad=%0d", $time,
                 res_bus.grad_index, res_bus.grad_value);
        error_count++;
      end else begin
        e = expected_q.pop_front();
        if (res_bus.grad_index !== e.idx) begin
          $display("%0t: grad_index exp %0d got %0d", $time, e.idx, res_bus.grad_index);
          error_count++;
        end
        if (res_bus.grad_value !== e.grad) begin
          $display("%0t: grad_value exp %0d got %0d", $time, e.grad, res_bus.grad_value);
          error_count++;
        end
        if (res_bus.total_value !== e.total) begin
          $display("%0t: total_value exp %0d got %0d", $time, e.total, res_bus.total_value);
          error_count++;
        end
        if (res_bus.total_valid !== e.tv) begin
          $display("%0t: total_valid exp %0b got %0b", $time, e.tv, res_bus.total_valid);
          error_count++;
        end
        if (res_bus.run_end !== e.re) begin
          $display("%0t: run_end exp %0b got %0b", $time, e.re, res_bus.run_end);
          error_count++;
        end
        if (res_bus.math_fault !== e.mf) begin
          $display("%0t: math_fault exp %0b got %0b", $time, e.mf, res_bus.math_fault);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel.
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, expected_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: extremes, zero roots, saturation, both register extremes
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows[] = '{
    // zero root on a lone element: every divisor is zero
    '{32'd0, 32'd0, 1'b1, 1'b1, '{0, 0, 0, 1, 1, 1}},
    // root exactly 1.0 with no weight: all terms vanish, no fault
    '{32'h0001_0000, 32'd0, 1'b1, 1'b1, '{0, 0, 0, 1, 1, 0}},
    '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'd0,         32'd1,         1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'd0,         32'hFFFF_FFFF, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
    // tiny roots with extreme weights saturate the gradient
    '{32'd1,         32'h7FFF_FFFF, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'd1,         32'h8000_0000, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'h1234_5678, 32'h0003_8000, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'h0000_4000, 32'hFFFE_0000, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}}
  };

  stim_row_t gain_rows[] = '{
    '{32'd1,         32'd1,         1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
    // zero last root makes the gain term divide by zero
    '{32'd0,         32'd0,         1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'hFFFF_FFFF, 32'd0,         1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'd2,         32'd3,         1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}}
  };

  task automatic walk_rows(stim_row_t rows[]);
    foreach (rows[r]) begin
      send_element(rows[r].x, rows[r].w, rows[r].fin);
      if (rows[r].has_lit) begin
        void'(expected_q.pop_back());
        expected_q.push_back(rows[r].lit);
      end
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    item_bus.valid         = 1'b0;
    item_bus.root_source   = '0;
    item_bus.step_weight   = '0;
    item_bus.final_element = 1'b0;
    res_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_SLOPE;
    cfg_bus.wdata          = '0;
    gain_q      = 0;
    offset_q    = 0;
    last_root   = 0;
    held_grad   = 0;
    run_sum     = 0;
    elem_idx    = 0;
    run_fault   = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    burst_left  = 0;
    stall_left  = 0;
    calm_left   = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with registers at their reset values first.
    walk_rows(dir_rows);
    set_regs(32'h7FFF_FFFF, 32'h8000_0000);
    walk_rows(gain_rows);
    set_regs(32'h8000_0000, 32'h7FFF_FFFF);
    walk_rows(gain_rows);

    // Random part across several register settings.
    set_regs($urandom, $urandom);
    send_vectors(6);
    set_regs(32'h0001_0000, 32'h0000_8000);
    // One over-long vector: the element at the last index closes it.
    for (int k = 0; k < LONG_RUN; k++)
      send_element(pick_root(), pick_weight(), 1'b0);
    send_element(pick_root(), pick_weight(), 1'b1);
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vectors(4);
    set_regs(32'h8000_0000, 32'h8000_0000);
    send_vectors(4);
    set_regs(32'd0, 32'd0);
    send_vectors(4);

    drain();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
